### src/ale_pkg.sv
// Package for the linear attack/release envelope generator.
// Holds the fixed-point widths, the phase and sequencer codes, the register map
// and the configuration struct. Depends on nothing.
`default_nettype none

package ale_pkg;

  // Unsigned fixed point: ONE = 2^FRAC_BITS stands for 1.0.
  localparam int FRAC_BITS = 24;
  localparam int LVL_W     = FRAC_BITS + 1;
  localparam int PROD_W    = 2 * LVL_W;
  localparam int CNT_W     = $clog2(LVL_W);

  localparam int APB_AW = 4;
  localparam int APB_DW = 32;

  typedef logic [LVL_W-1:0]  level_t;
  typedef logic [PROD_W-1:0] prod_t;

  localparam level_t ONE          = level_t'(1) << FRAC_BITS;
  localparam level_t ATTACK_RESET = level_t'(38044);
  localparam level_t RELEASE_RESET = level_t'(1522);

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_ATTACK  = 2'd1,
    PH_HOLD    = 2'd2,
    PH_RELEASE = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    ST_WAIT_IN,
    ST_REL_MUL,
    ST_UPDATE,
    ST_OUT_MUL,
    ST_PUSH
  } seq_state_e;

  typedef enum logic [1:0] {
    REG_TRIGGER_MODE     = 2'd0,
    REG_ATTACK_STEP      = 2'd1,
    REG_RELEASE_FRACTION = 2'd2,
    REG_AMPLITUDE        = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic   trigger_mode;
    level_t attack_step;
    level_t release_fraction;
    level_t amplitude;
  } cfg_t;

  // Keeps the low register bits and clamps them into [1, ONE] when zero_is_one is set, else [0, ONE].
  function automatic level_t sat_reg(logic [APB_DW-1:0] v, logic zero_is_one);
    level_t m;
    m = v[LVL_W-1:0];
    if (m > ONE) begin
      m = ONE;
    end else if (zero_is_one && (m == '0)) begin
      m = level_t'(1);
    end
    return m;
  endfunction

endpackage

`default_nettype wire

### src/ale_if.sv
// Handshake channels of the envelope generator: the gate sample input and the
// envelope result output. Depends on ale_pkg.
`default_nettype none

interface ale_in_if;
  import ale_pkg::*;

  logic valid;
  logic ready;
  logic gate_high;

  modport source (output valid, output gate_high, input ready);
  modport sink   (input valid, input gate_high, output ready);
endinterface

interface ale_out_if;
  import ale_pkg::*;

  logic       valid;
  logic       ready;
  level_t     envelope;
  logic [1:0] stage;

  modport source (output valid, output envelope, output stage, input ready);
  modport sink   (input valid, input envelope, input stage, output ready);
endinterface

`default_nettype wire

### src/ale_regs.sv
// APB-style configuration registers of the envelope generator.
// Saturates written values into range. Depends on ale_pkg.
`default_nettype none

module ale_regs (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         psel,
  input  wire                         penable,
  input  wire                         pwrite,
  input  wire [ale_pkg::APB_AW-1:0]   paddr,
  input  wire [ale_pkg::APB_DW-1:0]   pwdata,
  output logic [ale_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  output ale_pkg::cfg_t               cfg_o
);
  import ale_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_TRIGGER_MODE:     cfg_d.trigger_mode     = pwdata[0];
        REG_ATTACK_STEP:      cfg_d.attack_step      = sat_reg(pwdata, 1'b1);
        REG_RELEASE_FRACTION: cfg_d.release_fraction = sat_reg(pwdata, 1'b1);
        REG_AMPLITUDE:        cfg_d.amplitude        = sat_reg(pwdata, 1'b0);
        default:              cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_TRIGGER_MODE:     prdata = APB_DW'(cfg_q.trigger_mode);
      REG_ATTACK_STEP:      prdata = APB_DW'(cfg_q.attack_step);
      REG_RELEASE_FRACTION: prdata = APB_DW'(cfg_q.release_fraction);
      REG_AMPLITUDE:        prdata = APB_DW'(cfg_q.amplitude);
      default:              prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.trigger_mode     <= 1'b0;
      cfg_q.attack_step      <= ATTACK_RESET;
      cfg_q.release_fraction <= RELEASE_RESET;
      cfg_q.amplitude        <= ONE;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

### src/ale_mul.sv
// Bit-serial shift-and-add multiplier: one multiplier bit per cycle, a
// narrow adder, and the full product when done_o pulses. Depends on ale_pkg.
`default_nettype none

module ale_mul (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               start_i,
  input  ale_pkg::level_t   a_i,
  input  ale_pkg::level_t   b_i,
  output logic              done_o,
  output ale_pkg::prod_t    prod_o
);
  import ale_pkg::*;

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  level_t           hi_q, hi_d;
  level_t           lo_q, lo_d;
  level_t           b_q, b_d;
  logic [LVL_W:0]   sum;

  // The upper half never exceeds the multiplicand, so the sum fits LVL_W+1 bits.
  assign sum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, b_q} : '0);

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    hi_d   = hi_q;
    lo_d   = lo_q;
    b_d    = b_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      hi_d   = '0;
      lo_d   = a_i;
      b_d    = b_i;
    end else if (busy_q) begin
      hi_d  = sum[LVL_W:1];
      lo_d  = {sum[0], lo_q[LVL_W-1:1]};
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(LVL_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hi_q <= hi_d;
    lo_q <= lo_d;
    b_q  <= b_d;
  end

  assign done_o = done_q;
  assign prod_o = {hi_q, lo_q};

`ifndef SYNTHESIS
  a_start_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("multiplier started while busy");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> ($past(busy_q) && !busy_q))
    else $error("multiplier done without a finished run");
`endif

endmodule

`default_nettype wire

### src/linear_attack_release_envelope.sv
// Linear attack/release envelope generator: top level with the per-sample
// sequencer. Depends on ale_pkg, ale_if, ale_regs and ale_mul.
//
// Usage: each transfer on in_if carries one gate sample (gate_high); each
// sample yields exactly one transfer on out_if carrying the envelope value
// (unsigned, 2^24 = 1.0) and the phase after the sample (0 idle, 1 attack,
// 2 hold, 3 release). The APB port sets trigger mode, attack step, release
// fraction and amplitude; write it only while no sample is in flight.
// Sequencing: one sample is worked on at a time. With unity amplitude the
// sequencer goes from ST_UPDATE straight to ST_PUSH and the multiplier is not
// used. Otherwise the output product runs through the bit-serial multiplier,
// one bit per cycle over 25 bits, in ST_OUT_MUL. In gate mode, a low gate that
// starts a release (release fraction below one) first computes the release
// decrement on the same multiplier, in ST_REL_MUL, before the level update.
// The result goes into an output register, so in_if.ready returns as soon as
// the result is parked there; if the receiver stalls, the sequencer holds the
// next finished result until the output register frees up.
// Reset clears the phase, the level, the previous gate and the release
// decrement, loads the register defaults and empties the output register.
`default_nettype none

module linear_attack_release_envelope (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         psel,
  input  wire                         penable,
  input  wire                         pwrite,
  input  wire [ale_pkg::APB_AW-1:0]   paddr,
  input  wire [ale_pkg::APB_DW-1:0]   pwdata,
  output logic [ale_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  ale_in_if.sink                      in_if,
  ale_out_if.source                   out_if
);
  import ale_pkg::*;

  cfg_t       cfg;
  seq_state_e state_q, state_d;

  // Per-sample envelope state.
  phase_e phase_q, phase_d;
  level_t level_q, level_d;
  level_t step_q, step_d;
  logic   prev_q, prev_d;

  // Output register.
  logic       out_valid_q, out_valid_d;
  level_t     out_env_q, out_env_d;
  logic [1:0] out_stage_q, out_stage_d;

  // Sequencer controls.
  logic   in_ready;
  logic   accept;
  logic   mul_start;
  logic   out_load;
  logic   mul_done;
  level_t mul_a, mul_b;
  prod_t  prod;

  // Decode helpers.
  logic             trig, gate, rel_early;
  logic             attack_full, rel_full, amp_full;
  phase_e           ph_in;
  logic [LVL_W:0]   att_sum;
  logic             att_top;
  level_t           rel_ceil;
  level_t           prod_floor;
  level_t           rel_first;

  ale_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ale_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (prod)
  );

  assign trig        = cfg.trigger_mode;
  assign gate        = in_if.gate_high;
  assign attack_full = (cfg.attack_step >= ONE);
  assign rel_full    = (cfg.release_fraction >= ONE);
  assign amp_full    = (cfg.amplitude >= ONE);
  assign accept      = in_if.valid && in_ready;

  // Product scaled back by 2^FRAC_BITS, truncated and rounded up.
  assign prod_floor = prod[FRAC_BITS +: LVL_W];
  assign rel_ceil   = prod_floor + level_t'(|prod[FRAC_BITS-1:0]);

  // A release that starts from full scale needs no multiply: the decrement is
  // the release fraction itself.
  assign rel_first = rel_full ? ONE : cfg.release_fraction;

  assign att_sum = {1'b0, level_q} + {1'b0, cfg.attack_step};
  assign att_top = attack_full || (att_sum >= {1'b0, ONE});

  // Phase at the start of a sample, before the level update.
  always_comb begin
    ph_in = phase_q;
    if (!trig) begin
      if (gate && (!prev_q || (phase_q == PH_IDLE))) begin
        ph_in = PH_ATTACK;
      end
    end else if (gate && !prev_q) begin
      ph_in = PH_ATTACK;
    end
  end

  // In gate mode a low gate releases any active envelope, and a falling edge
  // releases even from idle.
  assign rel_early = !trig && !gate &&
                     (prev_q || ((phase_q != PH_RELEASE) && (phase_q != PH_IDLE)));

  // Next-state logic of the sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_WAIT_IN: begin
        if (accept) begin
          state_d = (rel_early && !rel_full) ? ST_REL_MUL : ST_UPDATE;
        end
      end
      ST_REL_MUL: begin
        if (mul_done) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        state_d = amp_full ? ST_PUSH : ST_OUT_MUL;
      end
      ST_OUT_MUL: begin
        if (mul_done) begin
          state_d = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (!out_valid_q || out_if.ready) begin
          state_d = ST_WAIT_IN;
        end
      end
      default: state_d = ST_WAIT_IN;
    endcase
  end

  // Output logic of the sequencer.
  always_comb begin
    in_ready  = 1'b0;
    mul_start = 1'b0;
    out_load  = 1'b0;
    mul_a     = level_q;
    mul_b     = cfg.release_fraction;
    case (state_q)
      ST_WAIT_IN: begin
        in_ready  = 1'b1;
        mul_start = accept && rel_early && !rel_full;
      end
      ST_UPDATE: begin
        mul_start = !amp_full;
        mul_a     = level_d;
        mul_b     = cfg.amplitude;
      end
      ST_PUSH: begin
        out_load = !out_valid_q || out_if.ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // Envelope datapath.
  always_comb begin
    phase_d = phase_q;
    level_d = level_q;
    step_d  = step_q;
    prev_d  = prev_q;
    case (state_q)
      ST_WAIT_IN: begin
        if (accept) begin
          prev_d  = gate;
          phase_d = rel_early ? PH_RELEASE : ph_in;
          if (rel_early && rel_full) begin
            step_d = level_q;
          end
        end
      end
      ST_REL_MUL: begin
        if (mul_done) begin
          step_d = rel_ceil;
        end
      end
      ST_UPDATE: begin
        case (phase_q)
          PH_ATTACK: begin
            if (att_top) begin
              level_d = ONE;
              if (!trig && prev_q) begin
                phase_d = PH_HOLD;
              end else begin
                phase_d = PH_RELEASE;
                step_d  = rel_first;
              end
            end else begin
              level_d = att_sum[LVL_W-1:0];
            end
          end
          PH_HOLD: begin
            level_d = ONE;
            if (!prev_q) begin
              phase_d = PH_RELEASE;
              step_d  = rel_first;
            end
          end
          PH_RELEASE: begin
            if (rel_full || (step_q >= level_q)) begin
              level_d = '0;
              step_d  = '0;
              phase_d = PH_IDLE;
            end else begin
              level_d = level_q - step_q;
            end
          end
          default: begin
            level_d = '0;
          end
        endcase
      end
      default: begin
        phase_d = phase_q;
      end
    endcase
  end

  // Output register: loads from the sequencer, drains on the receiver's transfer.
  always_comb begin
    out_valid_d = out_valid_q;
    out_env_d   = out_env_q;
    out_stage_d = out_stage_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      out_env_d   = amp_full ? level_q : prod_floor;
      out_stage_d = phase_q;
    end else if (out_if.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_WAIT_IN;
      phase_q     <= PH_IDLE;
      level_q     <= '0;
      step_q      <= '0;
      prev_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      level_q     <= level_d;
      step_q      <= step_d;
      prev_q      <= prev_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_env_q   <= out_env_d;
    out_stage_q <= out_stage_d;
  end

  assign in_if.ready     = in_ready;
  assign out_if.valid    = out_valid_q;
  assign out_if.envelope = out_env_q;
  assign out_if.stage    = out_stage_q;

`ifndef SYNTHESIS
  a_idle_is_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_IDLE) |-> (level_q == '0))
    else $error("idle phase with a nonzero level");

  a_level_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    level_q <= ONE)
    else $error("level above full scale");

  a_hold_is_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_HOLD) |-> (level_q == ONE))
    else $error("hold phase below full scale");

  a_busy_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q != ST_WAIT_IN))
    else $error("sequencer did not start on an input transfer");
`endif

endmodule

`default_nettype wire

### sim/ale_env_checker.sv
// Checker for the envelope generator: watches the APB port and both channels,
// predicts every envelope sample and compares it with what the block returns.
// Depends on ale_pkg and ale_if.
`default_nettype none

module ale_env_checker (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         psel_i,
  input  wire                         penable_i,
  input  wire                         pwrite_i,
  input  wire [ale_pkg::APB_AW-1:0]   paddr_i,
  input  wire [ale_pkg::APB_DW-1:0]   pwdata_i,
  input  wire [ale_pkg::APB_DW-1:0]   prdata_i,
  input  wire                         pready_i,
  ale_in_if                           in_ch,
  ale_out_if                          out_ch,
  output int unsigned                 pending_o,
  output int unsigned                 errors_o
);
  import ale_pkg::*;

  typedef struct packed {
    level_t envelope;
    phase_e stage;
  } env_sample_t;

  // Shadow copy of the registers.
  logic   trig_mode_q;
  level_t attack_q;
  level_t decay_frac_q;
  level_t gain_q;

  // Shadow copy of the envelope state.
  level_t level_q;
  level_t decay_step_q;
  logic   last_gate_q;
  phase_e phase_q;

  env_sample_t envelope_fifo[$];
  int unsigned results_seen;

  // Keeps the register width and clamps into [1 or 0, ONE].
  function automatic level_t clamp_reg(input logic [APB_DW-1:0] v, input logic floor_one);
    level_t m;
    m = v[LVL_W-1:0];
    if (m > ONE) begin
      m = ONE;
    end else if (floor_one && m == '0) begin
      m = level_t'(1);
    end
    return m;
  endfunction

  // The decrement is fixed at the level where the release starts and rounded up.
  function automatic void start_decay();
    prod_t scaled;
    phase_q = PH_RELEASE;
    if (decay_frac_q >= ONE) begin
      decay_step_q = level_q;
    end else begin
      scaled = prod_t'(level_q) * prod_t'(decay_frac_q) + prod_t'(ONE - level_t'(1));
      decay_step_q = level_t'(scaled >> FRAC_BITS);
    end
  endfunction

  function automatic env_sample_t advance_envelope(input logic gate);
    logic             rising;
    logic             falling;
    logic [LVL_W:0]   sum;
    prod_t            scaled;
    env_sample_t      res;
    rising      = gate && !last_gate_q;
    falling     = !gate && last_gate_q;
    last_gate_q = gate;

    if (!trig_mode_q) begin
      if (rising || (gate && phase_q == PH_IDLE)) phase_q = PH_ATTACK;
      if (falling) start_decay();
      if (!gate && phase_q != PH_RELEASE && phase_q != PH_IDLE) start_decay();
    end else if (rising) begin
      phase_q = PH_ATTACK;
    end

    case (phase_q)
      PH_ATTACK: begin
        if (attack_q >= ONE) begin
          level_q = ONE;
        end else begin
          sum = {1'b0, level_q} + {1'b0, attack_q};
          level_q = (sum >= {1'b0, ONE}) ? ONE : sum[LVL_W-1:0];
        end
        if (level_q >= ONE) begin
          if (!trig_mode_q && gate) begin
            phase_q = PH_HOLD;
          end else begin
            start_decay();
          end
        end
      end
      PH_HOLD: begin
        level_q = ONE;
        if (!gate) start_decay();
      end
      PH_RELEASE: begin
        if (decay_frac_q >= ONE || decay_step_q >= level_q) begin
          level_q      = '0;
          phase_q      = PH_IDLE;
          decay_step_q = '0;
        end else begin
          level_q = level_q - decay_step_q;
        end
      end
      default: level_q = '0;
    endcase

    if (gain_q >= ONE) begin
      res.envelope = level_q;
    end else begin
      scaled = prod_t'(level_q) * prod_t'(gain_q);
      res.envelope = level_t'(scaled >> FRAC_BITS);
    end
    res.stage = phase_q;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    $display("[%0t] mismatch on %s (result %0d): got %0d, expected %0d",
             $time, what, results_seen, got, want);
    errors_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    env_sample_t        want;
    logic [APB_DW-1:0]  reg_value;
    if (!rst_ni) begin
      trig_mode_q  = 1'b0;
      attack_q     = ATTACK_RESET;
      decay_frac_q = RELEASE_RESET;
      gain_q       = ONE;
      level_q      = '0;
      decay_step_q = '0;
      last_gate_q  = 1'b0;
      phase_q      = PH_IDLE;
      envelope_fifo.delete();
      results_seen = 0;
      errors_o     = 0;
      pending_o    = 0;
    end else begin
      if (psel_i && penable_i && pready_i) begin
        if (pwrite_i) begin
          case (reg_idx_e'(paddr_i[3:2]))
            REG_TRIGGER_MODE:     trig_mode_q  = pwdata_i[0];
            REG_ATTACK_STEP:      attack_q     = clamp_reg(pwdata_i, 1'b1);
            REG_RELEASE_FRACTION: decay_frac_q = clamp_reg(pwdata_i, 1'b1);
            default:              gain_q       = clamp_reg(pwdata_i, 1'b0);
          endcase
        end else begin
          case (reg_idx_e'(paddr_i[3:2]))
            REG_TRIGGER_MODE:     reg_value = APB_DW'(trig_mode_q);
            REG_ATTACK_STEP:      reg_value = APB_DW'(attack_q);
            REG_RELEASE_FRACTION: reg_value = APB_DW'(decay_frac_q);
            default:              reg_value = APB_DW'(gain_q);
          endcase
          if (prdata_i !== reg_value) begin
            report_mismatch($sformatf("register read at %0d", paddr_i), prdata_i, reg_value);
          end
        end
      end

      if (in_ch.valid && in_ch.ready) begin
        envelope_fifo.push_back(advance_envelope(in_ch.gate_high));
      end

      if (out_ch.valid && out_ch.ready) begin
        if (envelope_fifo.size() == 0) begin
          report_mismatch("result with nothing outstanding", out_ch.envelope, 0);
        end else begin
          want = envelope_fifo.pop_front();
          if (out_ch.envelope !== want.envelope) begin
            report_mismatch("envelope", out_ch.envelope, want.envelope);
          end
          if (out_ch.stage !== want.stage) begin
            report_mismatch("stage", out_ch.stage, want.stage);
          end
        end
        results_seen++;
      end
      pending_o = envelope_fifo.size();
    end
  end

endmodule

`default_nettype wire

### sim/tb_linear_attack_release_envelope.sv
// Testbench top for the linear attack/release envelope generator: drives gate
// samples and APB register writes, stalls the result side, and gives the verdict.
// Depends on ale_pkg, ale_if, ale_env_checker and the block itself.
`default_nettype none

module tb_linear_attack_release_envelope;
  import ale_pkg::*;

  // Cycles without any transfer or register access before the run is declared hung.
  localparam int unsigned HANG_LIMIT = 1000;
  // Quiet cycles after the last result.
  localparam int unsigned DRAIN_CYCLES = 80;
  localparam int unsigned PHASES = 8;
  localparam int unsigned ITEMS_PER_PHASE = 36;

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  int unsigned pending;
  int unsigned errors;
  int unsigned idle_cycles;

  // Gate samples waiting to be sent, filled by the directed and random parts.
  logic gate_plan[$];

  ale_in_if  in_ch();
  ale_out_if out_ch();

  linear_attack_release_envelope u_top (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_if   (in_ch),
    .out_if  (out_ch)
  );

  ale_env_checker u_checker (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_i  (prdata),
    .pready_i  (pready),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .pending_o (pending),
    .errors_o  (errors)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // All inputs change on the falling edge, so the block and the checker see
  // settled values at every rising edge.

  // One APB access: a setup cycle, then an access cycle that ends at the first
  // rising edge with pready high. Starts and ends at a falling edge.
  task automatic apb_access(input logic wr, input reg_idx_e idx,
                            input logic [APB_DW-1:0] data);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = {idx, 2'b00};
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // Writes all four registers and reads each back; the checker compares the
  // read data with its own clamped copy.
  task automatic program_regs(input logic trig, input logic [APB_DW-1:0] attack,
                              input logic [APB_DW-1:0] decay, input logic [APB_DW-1:0] gain);
    apb_access(1'b1, REG_TRIGGER_MODE, {$urandom} & ~APB_DW'(1) | APB_DW'(trig));
    apb_access(1'b1, REG_ATTACK_STEP, attack);
    apb_access(1'b1, REG_RELEASE_FRACTION, decay);
    apb_access(1'b1, REG_AMPLITUDE, gain);
    apb_access(1'b0, REG_TRIGGER_MODE, '0);
    apb_access(1'b0, REG_ATTACK_STEP, '0);
    apb_access(1'b0, REG_RELEASE_FRACTION, '0);
    apb_access(1'b0, REG_AMPLITUDE, '0);
  endtask

  // Registers may only change with nothing in flight. Every sample yields a
  // result, so once the checker has nothing outstanding the block is idle.
  task automatic wait_for_results();
    while (pending != 0) @(negedge clk);
  endtask

  // Presents one gate sample and holds it until the transfer happens.
  // Returns at the falling edge after the transfer with valid still high.
  task automatic send_gate(input logic g);
    in_ch.valid     = 1'b1;
    in_ch.gate_high = g;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Sends the whole plan in bursts of random length. A gap of zero keeps valid
  // high across the burst boundary, and now and then the sender holds off until
  // every outstanding result has come back.
  task automatic play_gate_plan();
    int unsigned burst_left;
    int unsigned gap;
    burst_left = $urandom_range(1, 16);
    while (gate_plan.size() != 0) begin
      send_gate(gate_plan.pop_front());
      burst_left--;
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        if (gap != 0) begin
          in_ch.valid = 1'b0;
          repeat (gap) @(negedge clk);
        end
        if ($urandom_range(0, 7) == 0) begin
          in_ch.valid = 1'b0;
          wait_for_results();
        end
        burst_left = $urandom_range(1, 16);
      end
    end
    in_ch.valid = 1'b0;
  endtask

  // Mostly well-formed gate pulses of random length, so attacks complete, holds
  // last and releases run; the rest is short runs of random gate bits.
  task automatic append_gate_segment();
    int unsigned high_len;
    int unsigned low_len;
    if ($urandom_range(0, 9) < 2) begin
      repeat ($urandom_range(1, 6)) gate_plan.push_back(1'($urandom_range(0, 1)));
    end else begin
      high_len = $urandom_range(1, 20);
      low_len  = $urandom_range(1, 24);
      repeat (high_len) gate_plan.push_back(1'b1);
      repeat (low_len) gate_plan.push_back(1'b0);
    end
  endtask

  // The receiver switches between stall patterns of random length: always
  // ready, random, a fixed duty cycle, and mostly stalled.
  initial begin
    int unsigned mode;
    int unsigned span;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(16, 96);
      for (int unsigned c = 0; c < span; c++) begin
        @(negedge clk);
        case (mode)
          0:       out_ch.ready = 1'b1;
          1:       out_ch.ready = 1'($urandom_range(0, 1));
          2:       out_ch.ready = (c % 6) < 4;
          default: out_ch.ready = ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Hang detection: any transfer or register access restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= HANG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    logic              trig;
    logic [APB_DW-1:0] attack;
    logic [APB_DW-1:0] decay;
    logic [APB_DW-1:0] gain;

    rst_n           = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    in_ch.valid     = 1'b0;
    in_ch.gate_high = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part.
    // Reset settings: the slow default attack is cut short by a falling gate,
    // which starts the release in the middle of the attack.
    gate_plan = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1};
    play_gate_plan();

    // Gate mode with an instant attack into hold, the smallest release fraction
    // (a zero write acts as one) and zero gain.
    wait_for_results();
    program_regs(1'b0, APB_DW'(ONE), 32'h0200_0000, '0);
    gate_plan = '{1'b1, 1'b1, 1'b0};
    play_gate_plan();

    // Trigger mode with attack step and amplitude written above full scale and the
    // release fraction at full scale: the rising edge jumps to full scale and releases at once.
    wait_for_results();
    program_regs(1'b1, 32'hFFFF_FFFF, APB_DW'(ONE), 32'h01FF_FFFF);
    gate_plan = '{1'b1, 1'b1};
    play_gate_plan();

    // Back to gate mode while the gate is still high and the phase is idle: the
    // falling gate starts a release from zero level, which goes straight back
    // to idle. Then the smallest attack step and the smallest nonzero gain.
    wait_for_results();
    program_regs(1'b0, '0, 32'd12345, 32'd1);
    gate_plan = '{1'b0, 1'b1, 1'b0};
    play_gate_plan();

    // A full gate-mode envelope through attack, hold and release at half gain.
    wait_for_results();
    program_regs(1'b0, APB_DW'(ONE / 2 + 1), APB_DW'(ONE / 3), APB_DW'(ONE / 2 + 12345));
    gate_plan = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0};
    play_gate_plan();

    // Random part. The mode alternates from phase to phase while the envelope
    // carries over, so mode changes land in the middle of envelopes.
    for (int unsigned p = 0; p < PHASES; p++) begin
      trig   = p[0];
      attack = (p == 3) ? APB_DW'(ONE) :
               (p == 6) ? $urandom : $urandom_range(ONE / 24, ONE / 3);
      decay  = (p == 5) ? 32'hFFFF_FFFF : $urandom_range(ONE / 40, ONE / 2);
      gain   = (p % 3 == 0) ? APB_DW'(ONE) :
               (p == 4) ? '0 :
               (p == 7) ? $urandom : $urandom_range(1, ONE - 1);
      wait_for_results();
      program_regs(trig, attack, decay, gain);
      gate_plan.delete();
      while (gate_plan.size() < ITEMS_PER_PHASE) append_gate_segment();
      play_gate_plan();
    end

    // Let every result come back, then leave room for anything unexpected.
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
